@@ hdl/nwt_pkg.sv @@
`timescale 1ns / 1ps

package nwt_pkg;

	// Table geometry
	localparam int ENTRIES_DEF = 64;
	localparam int ADDR_W      = 32;
	localparam int PORT_W      = 16;

	// Request codes
	localparam logic REQ_SAVE  = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOMATCH = 2'd2,
		ST_FULL    = 2'd3
	} nwt_status_t;

	// Request item
	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] key_addr;
		logic              key_addr_any;
		logic [PORT_W-1:0] key_pnum;
		logic              key_pnum_any;
		logic [ADDR_W-1:0] new_addr;
		logic [PORT_W-1:0] new_port;
	} nwt_req_t;

	// Result item
	typedef struct packed {
		nwt_status_t       status;
		logic [ADDR_W-1:0] out_addr;
		logic [PORT_W-1:0] out_port;
	} nwt_rsp_t;

	// Stored rule key; a wildcard part is kept as zero
	typedef struct packed {
		logic              addr_any;
		logic              port_any;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
	} nwt_key_t;

	// Stored translation
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
	} nwt_val_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EVAL,
		S_RESULT
	} nwt_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic start;
		logic scan;
		logic eval;
		logic load;
	} nwt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fill_zero;
		logic scan_last;
		logic out_free;
	} nwt_sts_t;

endpackage

@@ hdl/nwt_if.sv @@
`timescale 1ns / 1ps

interface nwt_req_if;
	import nwt_pkg::*;
	logic     valid;
	logic     ready;
	nwt_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nwt_rsp_if;
	import nwt_pkg::*;
	logic     valid;
	logic     ready;
	nwt_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/nat_wildcard_translation_table.sv @@
`timescale 1ns / 1ps

// Channel | Dir | Payload
// req     | in  | req_type, key_addr, key_addr_any, key_pnum, key_pnum_any, new_addr, new_port
// rsp     | out | status, out_addr, out_port
//
// Each request scans the stored rules one per cycle through a single key memory read
// port; the scan is skipped when the table is empty. Reset clears the fill count;
// rules fill from entry 0 upward and are never removed. The result sits in an output
// register; a new request is taken while it waits, and the next result is held back
// until the previous one is taken.

module nat_wildcard_translation_table import nwt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	nwt_req_if.sink   req,
	nwt_rsp_if.source rsp
);

	nwt_cmd_t cmd;
	nwt_sts_t sts;

	nwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nwt_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_data  (rsp.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready)
	);

endmodule

@@ hdl/nwt_ctrl.sv @@
`timescale 1ns / 1ps

module nwt_ctrl import nwt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  nwt_sts_t sts,
	output nwt_cmd_t cmd
);

	nwt_state_t state_q;
	nwt_state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = sts.fill_zero ? S_EVAL : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Drive commands
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_DRAIN: begin
				cmd = '0;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
			end
			S_RESULT: begin
				cmd.load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ hdl/nwt_dpath.sv @@
`timescale 1ns / 1ps

module nwt_dpath import nwt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  nwt_req_t req_data,
	input  nwt_cmd_t cmd,
	output nwt_sts_t sts,
	output nwt_rsp_t rsp_data,
	output logic     rsp_valid,
	input  logic     rsp_ready
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// Rule storage
	nwt_key_t key_mem [ENTRIES];
	nwt_val_t val_mem [ENTRIES];

	nwt_req_t    req_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] fill_q;

	logic          cmp_s1;
	logic [IW-1:0] cmp_idx_s1;
	nwt_key_t      key_s1;

	logic          hit_sv_q, hit_ex_q, hit_pw_q, hit_aw_q;
	logic [IW-1:0] idx_sv_q, idx_ex_q, idx_pw_q, idx_aw_q;

	nwt_status_t   res_status_q;
	logic          res_hit_q;
	nwt_val_t      val_rd_q;

	nwt_rsp_t      out_q;
	logic          out_valid_q;

	// Normalized request key
	logic [ADDR_W-1:0] norm_addr;
	logic [PORT_W-1:0] norm_port;
	assign norm_addr = req_q.key_addr_any ? '0 : req_q.key_addr;
	assign norm_port = req_q.key_pnum_any ? '0 : req_q.key_pnum;

	// Compare the fetched entry against the save key and the three lookup keys
	logic m_sv, m_ex, m_pw, m_aw;
	assign m_sv = key_s1.addr_any == req_q.key_addr_any
		&& key_s1.port_any == req_q.key_pnum_any
		&& key_s1.addr == norm_addr && key_s1.port == norm_port;
	assign m_ex = !key_s1.addr_any && !key_s1.port_any
		&& key_s1.addr == req_q.key_addr && key_s1.port == req_q.key_pnum;
	assign m_pw = !key_s1.addr_any && key_s1.port_any && key_s1.addr == req_q.key_addr;
	assign m_aw = key_s1.addr_any && !key_s1.port_any && key_s1.port == req_q.key_pnum;

	// Decide the outcome of the request
	logic          is_save, any_wild, both_wild, full, xl_hit;
	logic          wr_en, rd_en;
	logic [IW-1:0] wr_idx, rd_idx;
	nwt_status_t   status_d;

	assign is_save   = req_q.req_type == REQ_SAVE;
	assign any_wild  = req_q.key_addr_any || req_q.key_pnum_any;
	assign both_wild = req_q.key_addr_any && req_q.key_pnum_any;
	assign full      = fill_q == CW'(ENTRIES);
	assign xl_hit    = hit_ex_q || hit_pw_q || hit_aw_q;
	assign wr_idx    = hit_sv_q ? idx_sv_q : fill_q[IW-1:0];
	assign rd_idx    = hit_ex_q ? idx_ex_q : (hit_pw_q ? idx_pw_q : idx_aw_q);
	assign wr_en     = cmd.eval && is_save && !both_wild && (hit_sv_q || !full);
	assign rd_en     = cmd.eval && !is_save && !any_wild && xl_hit;

	always_comb begin
		if (is_save) begin
			if (both_wild) begin
				status_d = ST_INVALID;
			end else if (hit_sv_q || !full) begin
				status_d = ST_OK;
			end else begin
				status_d = ST_FULL;
			end
		end else begin
			if (any_wild) begin
				status_d = ST_INVALID;
			end else if (xl_hit) begin
				status_d = ST_OK;
			end else begin
				status_d = ST_NOMATCH;
			end
		end
	end

	// Key memory: one scan read per cycle, write on save
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx] <= '{addr_any: req_q.key_addr_any, port_any: req_q.key_pnum_any,
				addr: norm_addr, port: norm_port};
		end
		if (cmd.scan) begin
			key_s1 <= key_mem[idx_q];
		end
	end

	// Value memory: write on save, read on lookup hit
	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_mem[wr_idx] <= '{addr: req_q.new_addr, port: req_q.new_port};
		end
		if (rd_en) begin
			val_rd_q <= val_mem[rd_idx];
		end
	end

	// Hold the request, the result status and the compared index
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req_data;
		end
		if (cmd.eval) begin
			res_status_q <= status_d;
		end
		if (cmd.scan) begin
			cmp_idx_s1 <= idx_q;
		end
	end

	// Scan control, first-match tracking, fill count, result hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			fill_q    <= '0;
			cmp_s1    <= 1'b0;
			hit_sv_q  <= 1'b0;
			hit_ex_q  <= 1'b0;
			hit_pw_q  <= 1'b0;
			hit_aw_q  <= 1'b0;
			idx_sv_q  <= '0;
			idx_ex_q  <= '0;
			idx_pw_q  <= '0;
			idx_aw_q  <= '0;
			res_hit_q <= 1'b0;
		end else begin
			cmp_s1 <= cmd.scan;
			if (cmd.start) begin
				idx_q    <= '0;
				hit_sv_q <= 1'b0;
				hit_ex_q <= 1'b0;
				hit_pw_q <= 1'b0;
				hit_aw_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmp_s1) begin
					if (m_sv && !hit_sv_q) begin
						hit_sv_q <= 1'b1;
						idx_sv_q <= cmp_idx_s1;
					end
					if (m_ex && !hit_ex_q) begin
						hit_ex_q <= 1'b1;
						idx_ex_q <= cmp_idx_s1;
					end
					if (m_pw && !hit_pw_q) begin
						hit_pw_q <= 1'b1;
						idx_pw_q <= cmp_idx_s1;
					end
					if (m_aw && !hit_aw_q) begin
						hit_aw_q <= 1'b1;
						idx_aw_q <= cmp_idx_s1;
					end
				end
			end
			if (wr_en && !hit_sv_q) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.eval) begin
				res_hit_q <= rd_en;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.status   <= res_status_q;
			out_q.out_addr <= res_hit_q ? val_rd_q.addr : '0;
			out_q.out_port <= res_hit_q ? val_rd_q.port : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_data      = out_q;
	assign rsp_valid     = out_valid_q;
	assign sts.fill_zero = fill_q == '0;
	assign sts.scan_last = idx_q == IW'(fill_q - 1'b1);
	assign sts.out_free  = !out_valid_q || rsp_ready;

endmodule

@@ sim/tb_nat_wildcard_translation_table.sv @@
`timescale 1ns / 1ps

module tb_nat_wildcard_translation_table import nwt_pkg::*; ();

	localparam int N_RULES = ENTRIES_DEF;
	localparam int POOL_N  = 10;
	localparam int N_RAND  = 400;

	typedef struct {
		nwt_req_t req;
		bit       typed;
		nwt_rsp_t rsp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	nwt_req_if req ();
	nwt_rsp_if rsp ();

	nat_wildcard_translation_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the rule table
	bit       rule_used [N_RULES];
	nwt_key_t rule_key  [N_RULES];
	nwt_val_t rule_val  [N_RULES];

	// Results still owed by the block, oldest first
	nwt_rsp_t awaited_rsp_q [$];

	// Typed-in result that goes with the item now on the bus
	bit       row_typed;
	nwt_rsp_t row_rsp;

	logic [ADDR_W-1:0] pool_addr [POOL_N];
	logic [PORT_W-1:0] pool_port [POOL_N];

	int src_idle;
	int sink_idle;
	int n_bad;
	int n_saves;
	int n_xlates;
	int stat_seen [4];
	nwt_rsp_t want;
	nwt_rsp_t owed;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int find_rule(nwt_key_t k);
		for (int i = 0; i < N_RULES; i++) begin
			if (rule_used[i] && rule_key[i] == k)
				return i;
		end
		return -1;
	endfunction

	// Apply one request to the shadow table and return the result it should give
	function automatic nwt_rsp_t nat_table_step(nwt_req_t r);
		nwt_rsp_t res;
		nwt_key_t k;
		int slot;
		res = '0;
		res.status = ST_OK;
		if (r.req_type == REQ_SAVE) begin
			if (r.key_addr_any && r.key_pnum_any) begin
				res.status = ST_INVALID;
			end else begin
				// wildcard parts are stored as zero
				k.addr_any = r.key_addr_any;
				k.port_any = r.key_pnum_any;
				k.addr = r.key_addr_any ? '0 : r.key_addr;
				k.port = r.key_pnum_any ? '0 : r.key_pnum;
				slot = find_rule(k);
				for (int i = 0; i < N_RULES && slot < 0; i++) begin
					if (!rule_used[i])
						slot = i;
				end
				if (slot < 0) begin
					res.status = ST_FULL;
				end else begin
					rule_used[slot] = 1'b1;
					rule_key[slot] = k;
					rule_val[slot].addr = r.new_addr;
					rule_val[slot].port = r.new_port;
				end
			end
		end else if (r.key_addr_any || r.key_pnum_any) begin
			res.status = ST_INVALID;
		end else begin
			// exact, then wildcard port, then wildcard address
			k.addr_any = 1'b0;
			k.port_any = 1'b0;
			k.addr = r.key_addr;
			k.port = r.key_pnum;
			slot = find_rule(k);
			if (slot < 0) begin
				k.port_any = 1'b1;
				k.port = '0;
				slot = find_rule(k);
			end
			if (slot < 0) begin
				k.port_any = 1'b0;
				k.port = r.key_pnum;
				k.addr_any = 1'b1;
				k.addr = '0;
				slot = find_rule(k);
			end
			if (slot < 0) begin
				res.status = ST_NOMATCH;
			end else begin
				res.out_addr = rule_val[slot].addr;
				res.out_port = rule_val[slot].port;
			end
		end
		return res;
	endfunction

	function automatic dir_row_t mk_row(logic rt, logic [31:0] ka, logic aa, logic [15:0] kp,
			logic pa, logic [31:0] na, logic [15:0] np,
			bit typed, nwt_status_t st, logic [31:0] oa, logic [15:0] op);
		dir_row_t d;
		d.req.req_type = rt;
		d.req.key_addr = ka;
		d.req.key_addr_any = aa;
		d.req.key_pnum = kp;
		d.req.key_pnum_any = pa;
		d.req.new_addr = na;
		d.req.new_port = np;
		d.typed = typed;
		d.rsp.status = st;
		d.rsp.out_addr = oa;
		d.rsp.out_port = op;
		return d;
	endfunction

	// Mostly well-formed saves and lookups over a small key pool, some raw noise
	function automatic nwt_req_t gen_item();
		nwt_req_t it;
		int pick;
		pick = $urandom_range(99);
		it.req_type = 1'($urandom_range(1));
		it.key_addr = $urandom;
		it.key_addr_any = 1'($urandom_range(1));
		it.key_pnum = 16'($urandom_range(65535));
		it.key_pnum_any = 1'($urandom_range(1));
		it.new_addr = $urandom;
		it.new_port = 16'($urandom_range(65535));
		if (pick < 15)
			return it;
		it.key_addr = pool_addr[$urandom_range(POOL_N-1)];
		it.key_pnum = pool_port[$urandom_range(POOL_N-1)];
		it.key_addr_any = 1'b0;
		it.key_pnum_any = 1'b0;
		if (pick < 55) begin
			it.req_type = REQ_SAVE;
			case ($urandom_range(3))
				0: begin
					it.key_addr_any = 1'b1;
					it.key_addr = $urandom;
				end
				1: begin
					it.key_pnum_any = 1'b1;
					it.key_pnum = 16'($urandom_range(65535));
				end
				default: ;
			endcase
		end else begin
			it.req_type = REQ_XLATE;
			if ($urandom_range(9) == 0)
				it.key_pnum = 16'($urandom_range(65535));
		end
		return it;
	endfunction

	// Present one item, hold it until taken; call and return at a falling edge
	task automatic send_item(nwt_req_t item, bit typed, nwt_rsp_t typed_rsp);
		while ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= item;
		row_typed <= typed;
		row_rsp <= typed_rsp;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (awaited_rsp_q.size() != 0)
			@(negedge clk);
	endtask

	// Random stall on the result side
	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= sink_idle);

	// Predict on every accepted request, check every accepted result
	always @(posedge clk) begin
		if (req.valid === 1'b1 && req.ready === 1'b1) begin
			want = nat_table_step(req.data);
			awaited_rsp_q = {awaited_rsp_q, (row_typed ? row_rsp : want)};
			if (req.data.req_type == REQ_SAVE)
				n_saves++;
			else
				n_xlates++;
		end
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (awaited_rsp_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: status %0d addr %h port %h",
						rsp.data.status, rsp.data.out_addr, rsp.data.out_port);
			end else begin
				owed = awaited_rsp_q.pop_front();
				stat_seen[owed.status]++;
				if (rsp.data.status !== owed.status || rsp.data.out_addr !== owed.out_addr ||
						rsp.data.out_port !== owed.out_port) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: status %0d/%0d addr %h/%h port %h/%h (exp/got)",
							owed.status, rsp.data.status, owed.out_addr,
							rsp.data.out_addr, owed.out_port, rsp.data.out_port);
				end
			end
		end
	end

	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		dir_row_t dir_rows [$];
		int used;
		req.valid = 1'b0;
		req.data = '0;
		row_typed = 1'b0;
		row_rsp = '0;
		src_idle = 22;
		sink_idle = 63;
		n_bad = 0;
		n_saves = 0;
		n_xlates = 0;
		foreach (stat_seen[i])
			stat_seen[i] = 0;

		// Key pool with both extremes in it
		pool_addr[0] = '0;
		pool_addr[1] = '1;
		pool_port[0] = '0;
		pool_port[1] = '1;
		for (int i = 2; i < POOL_N; i++) begin
			pool_addr[i] = $urandom;
			pool_port[i] = 16'($urandom_range(65535));
		end

		// Lookups on an empty table, wildcard queries, double wildcard save
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0, 1'b0, 16'h0, 1'b0, 32'h0, 16'h0,
			1'b1, ST_NOMATCH, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'hFFFFFFFF, 1'b1, 16'hFFFF, 1'b0,
			32'hFFFFFFFF, 16'hFFFF, 1'b1, ST_INVALID, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0, 1'b0, 16'h0, 1'b1, 32'h0, 16'h0,
			1'b1, ST_INVALID, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'hFFFFFFFF, 1'b1, 16'hFFFF, 1'b1,
			32'hFFFFFFFF, 16'hFFFF, 1'b1, ST_INVALID, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'hFFFFFFFF, 1'b0, 16'hFFFF, 1'b0, 32'h0,
			16'h0, 1'b1, ST_NOMATCH, 32'h0, 16'h0)};
		// All-ones exact rule
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'hFFFFFFFF, 1'b0, 16'hFFFF, 1'b0,
			32'hFFFFFFFF, 16'hFFFF, 1'b1, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'hFFFFFFFF, 1'b0, 16'hFFFF, 1'b0, 32'h0,
			16'h0, 1'b1, ST_OK, 32'hFFFFFFFF, 16'hFFFF)};
		// Wildcard port rule, port value given but ignored
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'h0A000001, 1'b0, 16'h1234, 1'b1,
			32'hC0A80001, 16'h0050, 1'b1, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0A000001, 1'b0, 16'h0000, 1'b0, 32'h0,
			16'h0, 1'b0, ST_OK, 32'h0, 16'h0)};
		// Wildcard address rule, address value given but ignored
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'hDEADBEEF, 1'b1, 16'h0050, 1'b0,
			32'h0B0B0B0B, 16'h1F90, 1'b1, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h01020304, 1'b0, 16'h0050, 1'b0, 32'h0,
			16'h0, 1'b0, ST_OK, 32'h0, 16'h0)};
		// Wildcard port wins over wildcard address
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0A000001, 1'b0, 16'h0050, 1'b0, 32'h0,
			16'h0, 1'b0, ST_OK, 32'h0, 16'h0)};
		// Exact wins over both
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'h0A000001, 1'b0, 16'h0050, 1'b0, 32'h0,
			16'h0, 1'b1, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0A000001, 1'b0, 16'h0050, 1'b0, 32'h0,
			16'h0, 1'b0, ST_OK, 32'h0, 16'h0)};
		// Overwrite wildcard keys with a different ignored value
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'h0A000001, 1'b0, 16'hABCD, 1'b1,
			32'h12345678, 16'h4321, 1'b1, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0A000001, 1'b0, 16'h9999, 1'b0, 32'h0,
			16'h0, 1'b0, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'h00000000, 1'b1, 16'h0050, 1'b0,
			32'hAAAA5555, 16'h5AA5, 1'b1, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0A000002, 1'b0, 16'h0050, 1'b0, 32'h0,
			16'h0, 1'b0, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0A000002, 1'b0, 16'h0051, 1'b0, 32'h0,
			16'h0, 1'b0, ST_OK, 32'h0, 16'h0)};
		// All-zero exact key
		dir_rows = {dir_rows, mk_row(REQ_SAVE, 32'h0, 1'b0, 16'h0, 1'b0, 32'hFFFFFFFF, 16'h0,
			1'b1, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0, 1'b0, 16'h0, 1'b0, 32'h0, 16'h0,
			1'b0, ST_OK, 32'h0, 16'h0)};
		dir_rows = {dir_rows, mk_row(REQ_XLATE, 32'h0, 1'b1, 16'h0, 1'b1, 32'h0, 16'h0,
			1'b1, ST_INVALID, 32'h0, 16'h0)};

		// Reset once
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

		// Random phases: receiver-heavy idling, sender-heavy idling, none
		for (int ph = 0; ph < 3; ph++) begin
			req.valid <= 1'b0;
			wait_drained();
			src_idle = (ph == 0) ? 22 : (ph == 1) ? 63 : 0;
			sink_idle = (ph == 0) ? 63 : (ph == 1) ? 22 : 0;
			for (int n = 0; n < N_RAND / 3 + (ph == 2 ? N_RAND % 3 : 0); n++)
				send_item(gen_item(), 1'b0, '0);
		end
		req.valid <= 1'b0;
		wait_drained();
		repeat (2 * N_RULES + 10) @(negedge clk);

		used = 0;
		foreach (rule_used[i])
			used += rule_used[i];
		$display("covered %0d saves and %0d lookups, %0d of %0d rules in use at the end",
			n_saves, n_xlates, used, N_RULES);
		$display("results: %0d ok, %0d invalid, %0d no match, %0d table full",
			stat_seen[ST_OK], stat_seen[ST_INVALID], stat_seen[ST_NOMATCH], stat_seen[ST_FULL]);
		if (n_bad == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d failures", n_bad);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
